>>> hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, constants and lookup functions for the C subset token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Longest token length that is counted before the length saturates.
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  // Number of keywords that take part in matching, at most the table size.
  localparam int KEYWORD_COUNT = 15;
  localparam int KW_TABLE_SIZE = 15;
  localparam int KW_USED = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

  // Leading characters of a word that are kept for keyword matching.
  localparam int PREFIX_DEPTH = 8;
  localparam int PFX_IDX_W = $clog2(PREFIX_DEPTH);

  // Output queue depth; an item can push two records at once.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_KEYWORD    = 3'd0,
    KIND_IDENTIFIER = 3'd1,
    KIND_INTEGER    = 3'd2,
    KIND_SEPARATOR  = 3'd3,
    KIND_OPERATOR   = 3'd4
  } token_kind_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } byte_item_t;

  typedef struct packed {
    token_kind_t token_kind;
    logic [3:0]  token_index;
    logic [7:0]  token_length;
    logic        length_saturated;
    logic        last_of_run;
  } token_item_t;

  // Records produced by one accepted item, in output order.
  typedef struct packed {
    logic [1:0]  count;
    token_item_t first;
    token_item_t second;
  } cts_push_t;

  // Scanner state exposed for checking.
  typedef struct packed {
    scan_mode_t       mode;
    logic [LEN_W-1:0] len;
  } cts_scan_status_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] index;
  } kw_result_t;

  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

  // Keyword text, left aligned: character j sits at bits [63-8j -: 8].
  localparam logic [63:0] KW_TEXT [KW_TABLE_SIZE] = '{
    {"const", 24'h0}, {"int", 40'h0}, {"char", 32'h0}, {"void", 32'h0},
    {"main", 32'h0}, {"if", 48'h0}, {"else", 32'h0}, {"switch", 16'h0},
    {"case", 32'h0}, {"default", 8'h0}, {"while", 24'h0}, {"for", 40'h0},
    {"scanf", 24'h0}, {"printf", 16'h0}, {"return", 16'h0}
  };

  localparam int KW_LEN [KW_TABLE_SIZE] = '{5, 3, 4, 4, 4, 2, 4, 6, 4, 7, 5, 3, 5, 6, 6};

  localparam logic [7:0] SEP_CHARS [8] = '{";", ",", "{", "}", "[", "]", "(", ")"};
  localparam logic [7:0] OP_CHARS  [8] = '{"+", "-", "*", "/", ">", "<", "=", "!"};

  // Letter or underscore.
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Parallel compare of the stored prefix against every keyword; the lowest
  // matching table entry wins.
  function automatic kw_result_t kw_lookup(input prefix_t pfx, input logic [LEN_W-1:0] len,
                                           input logic ovf);
    kw_result_t res;
    logic       same;
    res.hit   = 1'b0;
    res.index = '0;
    for (int i = KW_USED - 1; i >= 0; i--) begin
      same = !ovf && (len == LEN_W'(KW_LEN[i]));
      for (int j = 0; j < PREFIX_DEPTH; j++) begin
        if (j < KW_LEN[i]) begin
          same = same && (pfx[j] == KW_TEXT[i][63-8*j -: 8]);
        end
      end
      if (same) begin
        res.hit   = 1'b1;
        res.index = 4'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> hdl/cts_scanner.sv
// ----------------------------------------------------------------------------
// cts_scanner
// Holds the pending token and turns one source byte into up to two records.
// ----------------------------------------------------------------------------
module cts_scanner (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  cts_pkg::byte_item_t       item,
  output cts_pkg::cts_push_t        push,
  output cts_pkg::cts_scan_status_t status
);

  cts_pkg::scan_mode_t           mode, mode_next;
  logic [cts_pkg::LEN_W-1:0]     len, len_next;
  logic                          ovf, ovf_next;
  cts_pkg::prefix_t              word_prefix;
  logic                          pfx_we;
  logic [cts_pkg::PFX_IDX_W-1:0] pfx_addr;

  logic                          c_alpha, c_digit, eoi, cont;
  logic                          have_flush, have_single;
  cts_pkg::kw_result_t           kw;
  cts_pkg::token_item_t          flush_rec, single_rec;

  assign eoi     = item.end_of_input;
  assign c_alpha = cts_pkg::is_alpha(item.char_in);
  assign c_digit = cts_pkg::is_digit(item.char_in);

  // The byte extends the pending word or number.
  assign cont = !eoi && ((mode == cts_pkg::MODE_WORD && (c_alpha || c_digit)) ||
                         (mode == cts_pkg::MODE_NUM && c_digit));

  assign kw = cts_pkg::kw_lookup(word_prefix, len, ovf);

  // Next state of the pending token and the prefix write.
  always_comb begin
    mode_next = mode;
    len_next  = len;
    ovf_next  = ovf;
    pfx_we    = 1'b0;
    pfx_addr  = '0;
    if (cont) begin
      if (len < cts_pkg::LEN_W'(cts_pkg::MAX_TOKEN_LEN)) begin
        pfx_we   = (len < cts_pkg::LEN_W'(cts_pkg::PREFIX_DEPTH));
        pfx_addr = len[cts_pkg::PFX_IDX_W-1:0];
        len_next = len + 1'b1;
      end else begin
        ovf_next = 1'b1;
      end
    end else if (!eoi && (c_alpha || c_digit)) begin
      mode_next = c_alpha ? cts_pkg::MODE_WORD : cts_pkg::MODE_NUM;
      len_next  = cts_pkg::LEN_W'(1);
      ovf_next  = 1'b0;
      pfx_we    = 1'b1;
    end else begin
      mode_next = cts_pkg::MODE_IDLE;
      len_next  = '0;
      ovf_next  = 1'b0;
    end
  end

  // Records: the flushed pending token first, then a one-character token.
  always_comb begin
    have_flush = (mode != cts_pkg::MODE_IDLE) && !cont;

    flush_rec.token_index      = '0;
    flush_rec.token_length     = 8'(len);
    flush_rec.length_saturated = ovf;
    flush_rec.last_of_run      = 1'b0;
    if (mode == cts_pkg::MODE_WORD) begin
      flush_rec.token_kind = kw.hit ? cts_pkg::KIND_KEYWORD : cts_pkg::KIND_IDENTIFIER;
      if (kw.hit) begin
        flush_rec.token_index = kw.index;
      end
    end else begin
      flush_rec.token_kind = cts_pkg::KIND_INTEGER;
    end

    have_single                 = 1'b0;
    single_rec.token_kind       = cts_pkg::KIND_SEPARATOR;
    single_rec.token_index      = '0;
    single_rec.token_length     = 8'd1;
    single_rec.length_saturated = 1'b0;
    single_rec.last_of_run      = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (item.char_in == cts_pkg::SEP_CHARS[i]) begin
        have_single            = 1'b1;
        single_rec.token_kind  = cts_pkg::KIND_SEPARATOR;
        single_rec.token_index = 4'(i);
      end
      if (item.char_in == cts_pkg::OP_CHARS[i]) begin
        have_single            = 1'b1;
        single_rec.token_kind  = cts_pkg::KIND_OPERATOR;
        single_rec.token_index = 4'(i);
      end
    end
    have_single = have_single && !eoi;

    push.count  = {1'b0, have_flush} + {1'b0, have_single};
    push.second = single_rec;
    if (have_flush) begin
      push.first             = flush_rec;
      push.first.last_of_run = !have_single;
    end else begin
      push.first = single_rec;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cts_pkg::MODE_IDLE;
      len  <= '0;
      ovf  <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      len  <= len_next;
      ovf  <= ovf_next;
    end
  end

  // Word prefix; entries are only read after they were written.
  always_ff @(posedge clk) begin
    if (take && pfx_we) begin
      word_prefix[pfx_addr] <= item.char_in;
    end
  end

  assign status.mode = mode;
  assign status.len  = len;

endmodule

>>> hdl/cts_out_queue.sv
// ----------------------------------------------------------------------------
// cts_out_queue
// Small record queue that takes up to two records a cycle and gives one while stall is low.
// ----------------------------------------------------------------------------
module cts_out_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_en,
  input  cts_pkg::cts_push_t          push,
  output logic                        room,
  output logic [cts_pkg::QCNT_W-1:0]  level,
  output logic                        valid,
  input  logic                        stall,
  output cts_pkg::token_item_t        item
);

  cts_pkg::token_item_t          entries [cts_pkg::QDEPTH];
  logic [cts_pkg::QPTR_W-1:0]    wr_ptr, wr_ptr_next, rd_ptr;
  logic [cts_pkg::QCNT_W-1:0]    count, count_next;
  logic [1:0]                    n_push;
  logic                          pop;

  assign n_push      = push_en ? push.count : 2'd0;
  assign pop         = valid && !stall;
  assign count_next  = count + cts_pkg::QCNT_W'(n_push) - cts_pkg::QCNT_W'(pop);
  assign wr_ptr_next = wr_ptr + 1'b1;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + cts_pkg::QPTR_W'(n_push);
      rd_ptr <= rd_ptr + cts_pkg::QPTR_W'(pop);
      count  <= count_next;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr_next] <= push.second;
    end
  end

  assign room  = (count <= cts_pkg::QCNT_W'(cts_pkg::QDEPTH - 2));
  assign level = count;
  assign valid = (count != '0);
  assign item  = entries[rd_ptr];

endmodule

>>> hdl/c_subset_token_scanner_core.sv
// ----------------------------------------------------------------------------
// c_subset_token_scanner_core
// Scans C subset source bytes and emits keyword, identifier, integer,
// separator and operator token records.
//
//   Channel  Handshake                      Payload
//   bytes    byte_valid / byte_stall        byte_item  (char_in, end_of_input)
//   tokens   token_valid / token_stall      token_item (kind, index, length, flags)
//
// One byte is accepted per cycle while byte_stall is low; its records are registered in the queue.
// A four-entry record queue decouples the sides; byte_stall rises while fewer
// than two entries are free. Reset (rst, synchronous) leaves the scanner idle
// and the queue empty.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  cts_pkg::byte_item_t  byte_item,
  output logic                 token_valid,
  input  logic                 token_stall,
  output cts_pkg::token_item_t token_item
);

  logic                        take;
  logic                        room;
  logic [cts_pkg::QCNT_W-1:0]  level;
  cts_pkg::cts_push_t          push;
  cts_pkg::cts_scan_status_t   status;

  assign byte_stall = !room;
  assign take       = byte_valid && room;

  // Token recognition.
  cts_scanner u_scanner (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (byte_item),
    .push   (push),
    .status (status)
  );

  // Record queue toward the token channel.
  cts_out_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_en (take),
    .push    (push),
    .room    (room),
    .level   (level),
    .valid   (token_valid),
    .stall   (token_stall),
    .item    (token_item)
  );

  // The queue never holds more records than it has entries.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= cts_pkg::QCNT_W'(cts_pkg::QDEPTH))
    else $error("record queue overfilled");

  // A pending length exists exactly while a word or number is pending.
  a_len_mode: assert property (@(posedge clk) disable iff (rst)
    (status.mode == cts_pkg::MODE_IDLE) == (status.len == '0))
    else $error("pending length disagrees with scan mode");

  // End of input always leaves the scanner idle.
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    take && byte_item.end_of_input |=> status.mode == cts_pkg::MODE_IDLE)
    else $error("scanner not idle after end of input");

  // One-character tokens carry a length of one and no saturation.
  a_single_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_item.token_kind == cts_pkg::KIND_SEPARATOR ||
                    token_item.token_kind == cts_pkg::KIND_OPERATOR)
    |-> token_item.token_length == 8'd1 && !token_item.length_saturated)
    else $error("bad single character token record");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Token scanner testbench
// Feeds C subset source bytes through the scanner and checks every token
// record. A built-in scanner model predicts the records for each accepted
// byte, and the queue of predicted records is matched against the output in
// order. The sender idles in bursts, and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 650;
  localparam int PRINT_LIMIT  = 30;
  localparam int KW_TOTAL     = 15;
  localparam int KW_MATCHED   = (cts_pkg::KEYWORD_COUNT < KW_TOTAL) ?
                                cts_pkg::KEYWORD_COUNT : KW_TOTAL;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 byte_valid  = 1'b0;
  logic                 byte_stall;
  cts_pkg::byte_item_t  byte_item   = '0;
  logic                 token_valid;
  logic                 token_stall = 1'b0;
  cts_pkg::token_item_t token_item;

  // Scanner model state.
  cts_pkg::scan_mode_t  sc_mode = cts_pkg::MODE_IDLE;
  logic [7:0]           sc_prefix [cts_pkg::PREFIX_DEPTH];
  int                   sc_len  = 0;
  bit                   sc_ovf  = 1'b0;

  cts_pkg::token_item_t expected_tokens [$];

  int          cycle_count     = 0;
  int          items_sent      = 0;
  int          records_checked = 0;
  int          mismatches      = 0;
  int          kind_tally [5]  = '{0, 0, 0, 0, 0};
  int          burst_left      = 0;
  int          rx_left         = 0;
  rx_pattern_t rx_pattern      = RX_FREE;

  c_subset_token_scanner_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item (token_item)
  );

  always #6 clk = ~clk;

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records still expected", cycle_count,
               expected_tokens.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Keyword spelling, right aligned with zero fill on the left.
  function automatic logic [63:0] keyword_spelling(input int i);
    case (i)
      0:       return "const";
      1:       return "int";
      2:       return "char";
      3:       return "void";
      4:       return "main";
      5:       return "if";
      6:       return "else";
      7:       return "switch";
      8:       return "case";
      9:       return "default";
      10:      return "while";
      11:      return "for";
      12:      return "scanf";
      13:      return "printf";
      14:      return "return";
      default: return 64'h0;
    endcase
  endfunction

  // Separators are entries 0 to 7, operators entries 8 to 15.
  function automatic logic [7:0] single_char(input int i);
    case (i)
      0:       return ";";
      1:       return ",";
      2:       return "{";
      3:       return "}";
      4:       return "[";
      5:       return "]";
      6:       return "(";
      7:       return ")";
      8:       return "+";
      9:       return "-";
      10:      return "*";
      11:      return "/";
      12:      return ">";
      13:      return "<";
      14:      return "=";
      default: return "!";
    endcase
  endfunction

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Appends one character to the pending token, saturating the length.
  function automatic void grow_token(input logic [7:0] c);
    if (sc_len < cts_pkg::MAX_TOKEN_LEN) begin
      if (sc_len < cts_pkg::PREFIX_DEPTH) begin
        sc_prefix[sc_len] = c;
      end
      sc_len++;
    end else begin
      sc_ovf = 1'b1;
    end
  endfunction

  function automatic void open_token(input cts_pkg::scan_mode_t m, input logic [7:0] c);
    sc_mode = m;
    sc_len  = 0;
    sc_ovf  = 1'b0;
    grow_token(c);
  endfunction

  // Ends the pending word or number, if any, and builds its record.
  function automatic bit close_token(output cts_pkg::token_item_t rec);
    logic [63:0] spelled;
    bit          had;
    had     = (sc_mode != cts_pkg::MODE_IDLE);
    spelled = '0;
    for (int j = 0; j < cts_pkg::PREFIX_DEPTH; j++) begin
      if (j < sc_len) begin
        spelled = {spelled[55:0], sc_prefix[j]};
      end
    end
    rec = '0;
    rec.token_length     = 8'(sc_len);
    rec.length_saturated = sc_ovf;
    if (sc_mode == cts_pkg::MODE_NUM) begin
      rec.token_kind = cts_pkg::KIND_INTEGER;
    end else begin
      rec.token_kind = cts_pkg::KIND_IDENTIFIER;
      // Words that fit the prefix are compared whole; lowest table entry wins.
      if (!sc_ovf && sc_len <= cts_pkg::PREFIX_DEPTH) begin
        for (int i = KW_MATCHED - 1; i >= 0; i--) begin
          if (spelled == keyword_spelling(i)) begin
            rec.token_kind  = cts_pkg::KIND_KEYWORD;
            rec.token_index = 4'(i);
          end
        end
      end
    end
    sc_mode = cts_pkg::MODE_IDLE;
    sc_len  = 0;
    sc_ovf  = 1'b0;
    return had;
  endfunction

  // Advances the scanner model by one byte and queues the records it causes.
  function automatic void scan_byte(input logic [7:0] c, input logic eoi);
    cts_pkg::token_item_t closed;
    cts_pkg::token_item_t single;
    bit                   has_closed;
    bit                   has_single;
    has_closed = 1'b0;
    has_single = 1'b0;
    single     = '0;
    if (!eoi && ((sc_mode == cts_pkg::MODE_WORD && (letter_char(c) || digit_char(c))) ||
                 (sc_mode == cts_pkg::MODE_NUM && digit_char(c)))) begin
      grow_token(c);
    end else begin
      // The terminating byte is scanned again after the flush.
      has_closed = close_token(closed);
      if (!eoi) begin
        if (letter_char(c)) begin
          open_token(cts_pkg::MODE_WORD, c);
        end else if (digit_char(c)) begin
          open_token(cts_pkg::MODE_NUM, c);
        end else begin
          for (int i = 0; i < 16; i++) begin
            if (!has_single && single_char(i) == c) begin
              has_single = 1'b1;
              if (i < 8) begin
                single.token_kind = cts_pkg::KIND_SEPARATOR;
              end else begin
                single.token_kind = cts_pkg::KIND_OPERATOR;
              end
              single.token_index  = 4'(i % 8);
              single.token_length = 8'd1;
            end
          end
        end
      end
    end
    if (has_closed) begin
      closed.last_of_run = !has_single;
      expected_tokens.push_back(closed);
    end
    if (has_single) begin
      single.last_of_run = 1'b1;
      expected_tokens.push_back(single);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Output checker: each accepted record against the oldest prediction.
  always @(posedge clk) begin
    cts_pkg::token_item_t want;
    if (!rst && token_valid && !token_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected record kind %0d index %0d length %0d",
                                  token_item.token_kind, token_item.token_index,
                                  token_item.token_length));
      end else begin
        want = expected_tokens.pop_front();
        records_checked++;
        kind_tally[int'(want.token_kind)]++;
        if (token_item.token_kind !== want.token_kind) begin
          report_mismatch($sformatf("token_kind %0d, want %0d", token_item.token_kind,
                                    want.token_kind));
        end
        if (token_item.token_index !== want.token_index) begin
          report_mismatch($sformatf("token_index %0d, want %0d", token_item.token_index,
                                    want.token_index));
        end
        if (token_item.token_length !== want.token_length) begin
          report_mismatch($sformatf("token_length %0d, want %0d", token_item.token_length,
                                    want.token_length));
        end
        if (token_item.length_saturated !== want.length_saturated) begin
          report_mismatch($sformatf("length_saturated %b, want %b",
                                    token_item.length_saturated, want.length_saturated));
        end
        if (token_item.last_of_run !== want.last_of_run) begin
          report_mismatch($sformatf("last_of_run %b, want %b", token_item.last_of_run,
                                    want.last_of_run));
        end
      end
    end
  end

  // Receiver stall: a randomly chosen pattern that is redrawn when its run ends.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_pattern)
      RX_FREE:  token_stall <= 1'b0;
      RX_LIGHT: token_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: token_stall <= ($urandom_range(0, 3) != 0);
      default:  token_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  // Sends one item, idling first when a burst has run out.
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_item  <= '{char_in: c, end_of_input: eoi};
    do @(posedge clk); while (byte_stall);
    scan_byte(c, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] word_start();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  // All separators and operators, each on its own and back to back.
  task automatic test_single_chars();
    for (int i = 0; i < 16; i++) begin
      send_byte(single_char(i), 1'b0);
    end
  endtask

  // A terminator that is also a token gives two records from one byte.
  task automatic test_words_and_numbers();
    send_text("if(");
    send_text("_Z9");
    send_byte(8'hFF, 1'b1);
    send_text("12.3");
    send_byte(8'h00, 1'b1);
    send_byte(";", 1'b1);
    send_text("Int-");
  endtask

  // High bytes, control bytes and the decimal point are all skipped.
  task automatic test_skipped_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("x");
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_text(" \t\n.");
  endtask

  // Lengths around the prefix size and around the saturation point.
  task automatic test_long_tokens();
    send_text("defaultz returns ");
    send_byte(word_start(), 1'b0);
    repeat (cts_pkg::MAX_TOKEN_LEN - 1) send_byte(word_char(), 1'b0);
    send_text(" ");
    send_byte(word_start(), 1'b0);
    repeat (cts_pkg::MAX_TOKEN_LEN + 44) send_byte(word_char(), 1'b0);
    send_text(";if ");
    repeat (cts_pkg::MAX_TOKEN_LEN + 1) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // One random lexeme: mostly well-formed tokens, some noise and flushes.
  task automatic send_random_lexeme();
    int          pick;
    int          n;
    int          cut;
    logic [63:0] spelled;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      // Keyword, sometimes cut short, extended or capitalized.
      spelled = keyword_spelling($urandom_range(0, KW_TOTAL - 1));
      n = 0;
      for (int b = 0; b < 8; b++) begin
        if (spelled[8*b +: 8] != 8'h00) n++;
      end
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
      for (int j = 0; j < cut; j++) begin
        c = spelled[8*(n-1-j) +: 8];
        if (j == 0 && $urandom_range(0, 9) == 0) c = c ^ 8'h20;
        send_byte(c, 1'b0);
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(word_char(), 1'b0);
      end
    end else if (pick < 40) begin
      n = ($urandom_range(0, 99) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 11);
      send_byte(word_start(), 1'b0);
      repeat (n - 1) send_byte(word_char(), 1'b0);
    end else if (pick < 54) begin
      n = ($urandom_range(0, 99) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 10);
      repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 4) == 0) begin
        send_byte(".", 1'b0);
        send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
    end else if (pick < 70) begin
      send_byte(single_char($urandom_range(0, 15)), 1'b0);
    end else if (pick < 84) begin
      send_byte(($urandom_range(0, 2) == 0) ? 8'h0A : " ", 1'b0);
    end else if (pick < 93) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_text();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_random_lexeme();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_single_chars();
    test_words_and_numbers();
    test_skipped_bytes();
    test_long_tokens();
    test_random_text();
    byte_valid <= 1'b0;

    // Drain the outstanding records, then watch for strays.
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Scanned %0d bytes into %0d token records, %0d mismatches.", items_sent,
             records_checked, mismatches);
    $display("Records by kind: keyword %0d, identifier %0d, integer %0d, separator %0d, %s %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], "operator",
             kind_tally[4]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cts_pkg.sv
hdl/cts_scanner.sv
hdl/cts_out_queue.sv
hdl/c_subset_token_scanner_core.sv
test/testbench.sv
